@@ sv/hsl2rgb_pkg.sv @@
// Constants, sector codes and channel helper for the HSL to RGB converter.
package hsl2rgb_pkg;

  localparam int HUE_W = 13;
  localparam int PCT_W = 11;
  localparam int CH_W  = 8;
  localparam int Q_W   = 17;   // Q16 values up to 1.0 inclusive

  localparam logic [Q_W-1:0]   ONE_Q16  = 17'd65536;
  localparam logic [PCT_W-1:0] PCT_FULL = 11'd1600;

  localparam logic [HUE_W-1:0] HUE_60  = 13'd960;
  localparam logic [HUE_W-1:0] HUE_120 = 13'd1920;
  localparam logic [HUE_W-1:0] HUE_180 = 13'd2880;
  localparam logic [HUE_W-1:0] HUE_240 = 13'd3840;
  localparam logic [HUE_W-1:0] HUE_300 = 13'd4800;
  localparam logic [HUE_W-1:0] HUE_360 = 13'd5760;
  localparam logic [HUE_W-1:0] HUE_480 = 13'd7680;

  // floor(n * 65536 / 1600) == (n * PCT_RECIP) >> 16 for n <= 1600
  localparam logic [21:0] PCT_RECIP = 22'd2684355;
  // floor(n / 15) == (n * DIV15_RECIP) >> 24 for n < 2^20
  localparam logic [20:0] DIV15_RECIP = 21'd1118482;

  localparam logic [CH_W-1:0] CHANNEL_MAX = 8'd255;

  // Hue sector: which channel takes C, X or zero (order red, green, blue)
  typedef enum logic [2:0] {
    SEC_CX0 = 3'd0,
    SEC_XC0 = 3'd1,
    SEC_0CX = 3'd2,
    SEC_0XC = 3'd3,
    SEC_X0C = 3'd4,
    SEC_C0X = 3'd5
  } sector_t;

  // ((p + m) * 255) >> 16, saturated to 0..255
  function automatic logic [CH_W-1:0] chan_sat(input logic [Q_W-1:0] p,
                                               input logic [Q_W-1:0] m);
    logic [Q_W:0]    sum;
    logic [Q_W+8:0]  scaled;
    logic [9:0]      trunc;
    sum    = {1'b0, p} + {1'b0, m};
    scaled = {sum, 8'd0} - {8'd0, sum};
    trunc  = scaled[Q_W+8:16];
    if (trunc > {2'd0, CHANNEL_MAX}) begin
      return CHANNEL_MAX;
    end
    return trunc[CH_W-1:0];
  endfunction

endpackage

@@ sv/hsl_to_rgb_converter_core.sv @@
// HSL to RGB converter: five-stage pipeline with per-stage flow control.
// An input request passes through stage registers 1 to 5 to the output request.
// Throughput: one color per cycle while out_ready does not stall the output;
// stage 1 holds two constant multipliers, stages 2, 3, 4 one multiplier each.
// Each stage takes a new request when it is empty or its successor moves, so
// bubbles fill while the output waits.
// Reset (synchronous, rst_n low) clears all stage valid bits; data is not reset.
module hsl_to_rgb_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] in_hue,
  input  logic [10:0] in_saturation,
  input  logic [10:0] in_lightness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam int QW = hsl2rgb_pkg::Q_W;

  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  assign en5      = !out_valid_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) out_valid_r <= v4_r;
    end
  end

  // ---- stage 1: clamp, scale to Q16, hue folding and sector ----
  logic [10:0] sp_c, lp_c;
  logic [32:0] s_prod, l_prod;
  logic [12:0] hm_w;
  logic [10:0] hm;
  logic [10:0] f;
  logic [9:0]  w_nxt;
  hsl2rgb_pkg::sector_t sec_nxt;

  assign sp_c   = (in_saturation > hsl2rgb_pkg::PCT_FULL) ? hsl2rgb_pkg::PCT_FULL
                                                          : in_saturation;
  assign lp_c   = (in_lightness > hsl2rgb_pkg::PCT_FULL) ? hsl2rgb_pkg::PCT_FULL
                                                         : in_lightness;
  assign s_prod = {22'd0, sp_c} * {11'd0, hsl2rgb_pkg::PCT_RECIP};
  assign l_prod = {22'd0, lp_c} * {11'd0, hsl2rgb_pkg::PCT_RECIP};

  always_comb begin
    if (in_hue >= hsl2rgb_pkg::HUE_480) begin
      hm_w = in_hue - hsl2rgb_pkg::HUE_480;
    end else if (in_hue >= hsl2rgb_pkg::HUE_360) begin
      hm_w = in_hue - hsl2rgb_pkg::HUE_360;
    end else if (in_hue >= hsl2rgb_pkg::HUE_240) begin
      hm_w = in_hue - hsl2rgb_pkg::HUE_240;
    end else if (in_hue >= hsl2rgb_pkg::HUE_120) begin
      hm_w = in_hue - hsl2rgb_pkg::HUE_120;
    end else begin
      hm_w = in_hue;
    end
    hm = hm_w[10:0];
    if (hm >= hsl2rgb_pkg::HUE_60[10:0]) begin
      f = hm - hsl2rgb_pkg::HUE_60[10:0];
    end else begin
      f = hsl2rgb_pkg::HUE_60[10:0] - hm;
    end
    w_nxt = hsl2rgb_pkg::HUE_60[9:0] - f[9:0];

    if (in_hue < hsl2rgb_pkg::HUE_60) begin
      sec_nxt = hsl2rgb_pkg::SEC_CX0;
    end else if (in_hue < hsl2rgb_pkg::HUE_120) begin
      sec_nxt = hsl2rgb_pkg::SEC_XC0;
    end else if (in_hue < hsl2rgb_pkg::HUE_180) begin
      sec_nxt = hsl2rgb_pkg::SEC_0CX;
    end else if (in_hue < hsl2rgb_pkg::HUE_240) begin
      sec_nxt = hsl2rgb_pkg::SEC_0XC;
    end else if (in_hue < hsl2rgb_pkg::HUE_300) begin
      sec_nxt = hsl2rgb_pkg::SEC_X0C;
    end else begin
      sec_nxt = hsl2rgb_pkg::SEC_C0X;  // also hue at or past 360, no wrap
    end
  end

  logic [QW-1:0] s1_r, l1_r;
  logic [9:0]    w1_r;
  hsl2rgb_pkg::sector_t sec1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r   <= s_prod[32:16];
      l1_r   <= l_prod[32:16];
      w1_r   <= w_nxt;
      sec1_r <= sec_nxt;
    end
  end

  // ---- stage 2: chroma ----
  logic [QW:0]     twol;
  logic [QW-1:0]   d_val, a_val;
  logic [2*QW-1:0] c_prod;

  assign twol = {l1_r, 1'b0};
  always_comb begin
    if (twol >= {1'b0, hsl2rgb_pkg::ONE_Q16}) begin
      d_val = QW'(twol - {1'b0, hsl2rgb_pkg::ONE_Q16});
    end else begin
      d_val = QW'({1'b0, hsl2rgb_pkg::ONE_Q16} - twol);
    end
  end
  assign a_val  = hsl2rgb_pkg::ONE_Q16 - d_val;
  assign c_prod = {{QW{1'b0}}, a_val} * {{QW{1'b0}}, s1_r};

  logic [QW-1:0] c2_r, l2_r;
  logic [9:0]    w2_r;
  hsl2rgb_pkg::sector_t sec2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      c2_r   <= c_prod[2*QW-2:16];
      l2_r   <= l1_r;
      w2_r   <= w1_r;
      sec2_r <= sec1_r;
    end
  end

  // ---- stage 3: C * (960 - f) and offset m ----
  logic [QW+9:0] cw_nxt;
  logic [QW-1:0] m_nxt;

  assign cw_nxt = {10'd0, c2_r} * {{QW{1'b0}}, w2_r};
  assign m_nxt  = l2_r - (c2_r >> 1);

  logic [QW+9:0] cw3_r;
  logic [QW-1:0] c3_r, m3_r;
  hsl2rgb_pkg::sector_t sec3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      cw3_r  <= cw_nxt;
      c3_r   <= c2_r;
      m3_r   <= m_nxt;
      sec3_r <= sec2_r;
    end
  end

  // ---- stage 4: X = (C * w) / 960 as ((C * w) >> 6) / 15 ----
  logic [20:0] n_div;
  logic [41:0] x_prod;

  assign n_div  = cw3_r[QW+9:6];
  assign x_prod = {21'd0, n_div} * {21'd0, hsl2rgb_pkg::DIV15_RECIP};

  logic [QW-1:0] x4_r, c4_r, m4_r;
  hsl2rgb_pkg::sector_t sec4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      x4_r   <= x_prod[40:24];
      c4_r   <= c3_r;
      m4_r   <= m3_r;
      sec4_r <= sec3_r;
    end
  end

  // ---- stage 5: sector select, offset, scale to 8 bits ----
  logic [QW-1:0] rp, gp, bp;

  always_comb begin
    case (sec4_r)
      hsl2rgb_pkg::SEC_CX0: begin rp = c4_r; gp = x4_r; bp = '0;   end
      hsl2rgb_pkg::SEC_XC0: begin rp = x4_r; gp = c4_r; bp = '0;   end
      hsl2rgb_pkg::SEC_0CX: begin rp = '0;   gp = c4_r; bp = x4_r; end
      hsl2rgb_pkg::SEC_0XC: begin rp = '0;   gp = x4_r; bp = c4_r; end
      hsl2rgb_pkg::SEC_X0C: begin rp = x4_r; gp = '0;   bp = c4_r; end
      default:              begin rp = c4_r; gp = '0;   bp = x4_r; end
    endcase
  end

  logic [7:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      red_r   <= hsl2rgb_pkg::chan_sat(rp, m4_r);
      green_r <= hsl2rgb_pkg::chan_sat(gp, m4_r);
      blue_r  <= hsl2rgb_pkg::chan_sat(bp, m4_r);
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // ---- checks ----
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r)
    else $error("input stalled with stage 1 empty");

  a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (w1_r <= hsl2rgb_pkg::HUE_60[9:0]))
    else $error("hue weight above 60 degrees");

  a_c_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (c2_r <= hsl2rgb_pkg::ONE_Q16 && (c2_r >> 1) <= l2_r))
    else $error("chroma out of range");

  a_x_le_c: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (x4_r <= c4_r))
    else $error("second component exceeds chroma");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && en5) |=> out_valid_r)
    else $error("request lost between stage 4 and output");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the HSL to RGB converter pipeline.
`timescale 1ns / 1ps

module testbench;

  localparam int HUE_W = hsl2rgb_pkg::HUE_W;
  localparam int PCT_W = hsl2rgb_pkg::PCT_W;
  localparam int CH_W  = hsl2rgb_pkg::CH_W;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RANDOM_COLORS  = 1430;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic             clk;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [HUE_W-1:0] in_hue        = '0;
  logic [PCT_W-1:0] in_saturation = '0;
  logic [PCT_W-1:0] in_lightness  = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;

  rgb_t pending_rgb_q[$];
  int   error_count = 0;
  bit   steady      = 1'b0;   // both sides stop idling while set

  hsl_to_rgb_converter_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ((p + m) * 255) >> 16, clipped at full scale
  function automatic logic [CH_W-1:0] to_channel(input logic [63:0] p, input logic [63:0] m);
    logic [63:0] v;
    v = ((p + m) * 64'd255) >> 16;
    if (v > 64'd255) begin
      return 8'd255;
    end
    return v[CH_W-1:0];
  endfunction

  function automatic rgb_t convert_hsl(input logic [HUE_W-1:0] hue,
                                       input logic [PCT_W-1:0] sat_pct,
                                       input logic [PCT_W-1:0] light_pct);
    logic [63:0] h, sp, lp, s, l, d, c, hm, f, x, m, pr, pg, pb;
    logic [63:0] h60;
    hsl2rgb_pkg::sector_t sec;
    rgb_t        rgb;
    h   = 64'(hue);
    h60 = 64'(hsl2rgb_pkg::HUE_60);
    sp  = (sat_pct > hsl2rgb_pkg::PCT_FULL) ? 64'(hsl2rgb_pkg::PCT_FULL) : 64'(sat_pct);
    lp  = (light_pct > hsl2rgb_pkg::PCT_FULL) ? 64'(hsl2rgb_pkg::PCT_FULL) : 64'(light_pct);
    s   = (sp * 64'd65536) / 64'(hsl2rgb_pkg::PCT_FULL);
    l   = (lp * 64'd65536) / 64'(hsl2rgb_pkg::PCT_FULL);
    d   = (2 * l >= 64'd65536) ? (2 * l - 64'd65536) : (64'd65536 - 2 * l);
    c   = ((64'd65536 - d) * s) >> 16;
    hm  = h % 64'(hsl2rgb_pkg::HUE_120);
    f   = (hm >= h60) ? (hm - h60) : (h60 - hm);
    x   = (c * (h60 - f)) / h60;
    m   = l - (c >> 1);
    // no wrap above 360 degrees: anything past 300 stays in the last sector
    if (hue < hsl2rgb_pkg::HUE_60) begin
      sec = hsl2rgb_pkg::SEC_CX0;
    end else if (hue < hsl2rgb_pkg::HUE_120) begin
      sec = hsl2rgb_pkg::SEC_XC0;
    end else if (hue < hsl2rgb_pkg::HUE_180) begin
      sec = hsl2rgb_pkg::SEC_0CX;
    end else if (hue < hsl2rgb_pkg::HUE_240) begin
      sec = hsl2rgb_pkg::SEC_0XC;
    end else if (hue < hsl2rgb_pkg::HUE_300) begin
      sec = hsl2rgb_pkg::SEC_X0C;
    end else begin
      sec = hsl2rgb_pkg::SEC_C0X;
    end
    case (sec)
      hsl2rgb_pkg::SEC_CX0: begin pr = c; pg = x; pb = 0; end
      hsl2rgb_pkg::SEC_XC0: begin pr = x; pg = c; pb = 0; end
      hsl2rgb_pkg::SEC_0CX: begin pr = 0; pg = c; pb = x; end
      hsl2rgb_pkg::SEC_0XC: begin pr = 0; pg = x; pb = c; end
      hsl2rgb_pkg::SEC_X0C: begin pr = x; pg = 0; pb = c; end
      default:              begin pr = c; pg = 0; pb = x; end
    endcase
    rgb.red   = to_channel(pr, m);
    rgb.green = to_channel(pg, m);
    rgb.blue  = to_channel(pb, m);
    return rgb;
  endfunction

  // Drive one color request; returns at the edge where it is accepted.
  task automatic send_color(input logic [HUE_W-1:0] hue,
                            input logic [PCT_W-1:0] sat_pct,
                            input logic [PCT_W-1:0] light_pct);
    while (!steady && $urandom_range(99) < 6) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_hue        <= HUE_W'($urandom);
      in_saturation <= PCT_W'($urandom);
      in_lightness  <= PCT_W'($urandom);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat_pct;
    in_lightness  <= light_pct;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_rgb_q.push_back(convert_hsl(hue, sat_pct, light_pct));
  endtask

  task automatic test_sector_edges();
    logic [HUE_W-1:0] edges[12];
    edges = '{13'd0, 13'd959, hsl2rgb_pkg::HUE_60, 13'd1919,
              hsl2rgb_pkg::HUE_120, 13'd2879, hsl2rgb_pkg::HUE_180, 13'd3839,
              hsl2rgb_pkg::HUE_240, 13'd4799, hsl2rgb_pkg::HUE_300, 13'd5759};
    foreach (edges[i]) begin
      send_color(edges[i], hsl2rgb_pkg::PCT_FULL, 11'd800);
    end
  endtask

  task automatic test_sat_light_extremes();
    send_color(13'd0, 11'd0, 11'd0);
    send_color(13'd500, hsl2rgb_pkg::PCT_FULL, 11'd0);
    send_color(13'd2000, hsl2rgb_pkg::PCT_FULL, hsl2rgb_pkg::PCT_FULL);
    send_color(13'd3000, 11'd2047, 11'd2047);
    send_color(13'd4000, 11'd0, hsl2rgb_pkg::PCT_FULL);
    send_color(13'd1000, 11'd1601, 11'd1200);
  endtask

  // hue at or past 360 degrees stays in the last sector
  task automatic test_hue_overflow();
    send_color(hsl2rgb_pkg::HUE_360, hsl2rgb_pkg::PCT_FULL, 11'd800);
    send_color(13'd7679, 11'd1200, 11'd600);
    send_color(hsl2rgb_pkg::HUE_480, hsl2rgb_pkg::PCT_FULL, 11'd400);
    send_color(13'd8191, 11'd2047, 11'd1000);
  endtask

  task automatic test_random_colors();
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat_pct;
    logic [PCT_W-1:0] light_pct;
    for (int n = 0; n < RANDOM_COLORS; n++) begin
      steady = (n >= 300 && n < 600);
      if ($urandom_range(99) < 85) begin
        hue       = HUE_W'($urandom_range(5759));
        sat_pct   = PCT_W'($urandom_range(1600));
        light_pct = PCT_W'($urandom_range(1600));
      end else begin
        hue       = HUE_W'($urandom);
        sat_pct   = PCT_W'($urandom);
        light_pct = PCT_W'($urandom);
      end
      send_color(hue, sat_pct, light_pct);
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rgb_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected result r=%0d g=%0d b=%0d", out_red, out_green, out_blue);
        end
      end else begin
        want = pending_rgb_q.pop_front();
        if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, out_red, out_green, out_blue);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_sector_edges();
    test_sat_light_extremes();
    test_hue_overflow();
    test_random_colors();
    while (pending_rgb_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_rgb_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
